FILE: design/midienc_pkg.sv
package midienc_pkg;

	// Message kinds carried on the func field.
	localparam logic [3:0] FN_NOTE_ON   = 4'd0;
	localparam logic [3:0] FN_NOTE_OFF  = 4'd1;
	localparam logic [3:0] FN_PROGRAM   = 4'd2;
	localparam logic [3:0] FN_BANK_PRG  = 4'd3;
	localparam logic [3:0] FN_PAN       = 4'd4;
	localparam logic [3:0] FN_VOLUME    = 4'd5;
	localparam logic [3:0] FN_BEND_SENS = 4'd6;
	localparam logic [3:0] FN_BEND      = 4'd7;
	localparam logic [3:0] FN_GM_ON     = 4'd8;
	localparam logic [3:0] FN_GS_RESET  = 4'd9;
	localparam logic [3:0] FN_GS_DRUM   = 4'd10;

	// Status nibbles and fixed bytes of the protocol.
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_CTRL     = 4'hB;
	localparam logic [3:0] ST_PROGRAM  = 4'hC;
	localparam logic [3:0] ST_BEND     = 4'hE;
	localparam logic [7:0] SYX_START   = 8'hF0;
	localparam logic [7:0] SYX_END     = 8'hF7;
	localparam logic [7:0] CC_PAN      = 8'h0A;
	localparam logic [7:0] CC_VOLUME   = 8'h07;
	localparam logic [7:0] CC_DATA     = 8'h06;
	localparam logic [7:0] CC_RPN_LSB  = 8'h64;
	localparam logic [7:0] CC_RPN_MSB  = 8'h65;
	localparam logic [7:0] RPN_NULL    = 8'h7F;
	localparam logic [7:0] ROLAND_ID   = 8'h41;
	localparam logic [7:0] GS_MODEL    = 8'h42;
	localparam logic [7:0] DT1_CMD     = 8'h12;
	localparam logic [6:0] GS_ADDR_HI  = 7'h40;
	localparam logic [6:0] DRUM_ADDR   = 7'h15;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic [3:0] func;
		logic [3:0] ch;
		logic [3:0] count;
		logic [6:0] x;
		logic [6:0] y;
		logic [6:0] z;
		logic [6:0] w;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] level;
	} qstat_t;

	// Clamp a signed value to 0..hi.
	function automatic logic [6:0] sat_hi(logic signed [16:0] v, logic [6:0] hi);
		logic signed [16:0] hi_s;
		hi_s = $signed({10'd0, hi});
		if (v < 17'sd0) begin
			return 7'd0;
		end else if (v > hi_s) begin
			return hi;
		end else begin
			return v[6:0];
		end
	endfunction

	// Byte number idx of the message stream for one request.
	function automatic logic [7:0] byte_at(cmd_t c, logic [3:0] idx);
		logic [7:0] cc;
		logic [7:0] res;
		cc = {ST_CTRL, c.ch};
		res = 8'h00;
		case (c.func)
			FN_NOTE_ON, FN_NOTE_OFF, FN_BEND: begin
				case (idx)
					4'd0: begin
						if (c.func == FN_NOTE_ON) begin
							res = {ST_NOTE_ON, c.ch};
						end else if (c.func == FN_NOTE_OFF) begin
							res = {ST_NOTE_OFF, c.ch};
						end else begin
							res = {ST_BEND, c.ch};
						end
					end
					4'd1: res = {1'b0, c.x};
					default: res = {1'b0, c.y};
				endcase
			end
			FN_PROGRAM: begin
				case (idx)
					4'd0: res = {ST_PROGRAM, c.ch};
					default: res = {1'b0, c.x};
				endcase
			end
			FN_BANK_PRG: begin
				case (idx)
					4'd0: res = cc;
					4'd1: res = 8'h00;
					4'd2: res = {1'b0, c.y};
					4'd3: res = {ST_PROGRAM, c.ch};
					default: res = {1'b0, c.x};
				endcase
			end
			FN_PAN, FN_VOLUME: begin
				case (idx)
					4'd0: res = cc;
					4'd1: res = (c.func == FN_PAN) ? CC_PAN : CC_VOLUME;
					default: res = {1'b0, c.x};
				endcase
			end
			FN_BEND_SENS: begin
				case (idx)
					4'd0, 4'd3, 4'd6, 4'd9, 4'd12: res = cc;
					4'd1, 4'd10: res = CC_RPN_LSB;
					4'd4, 4'd13: res = CC_RPN_MSB;
					4'd7: res = CC_DATA;
					4'd8: res = {1'b0, c.x};
					4'd11, 4'd14: res = RPN_NULL;
					default: res = 8'h00;
				endcase
			end
			FN_GM_ON: begin
				case (idx)
					4'd0: res = SYX_START;
					4'd1: res = 8'h7E;
					4'd2: res = 8'h7F;
					4'd3: res = 8'h09;
					4'd4: res = 8'h01;
					default: res = SYX_END;
				endcase
			end
			FN_GS_RESET, FN_GS_DRUM: begin
				case (idx)
					4'd0: res = SYX_START;
					4'd1: res = ROLAND_ID;
					4'd2: res = {1'b0, c.x};
					4'd3: res = GS_MODEL;
					4'd4: res = DT1_CMD;
					4'd5: res = {1'b0, GS_ADDR_HI};
					4'd6: res = {1'b0, c.y};
					4'd7: res = (c.func == FN_GS_DRUM) ? {1'b0, DRUM_ADDR} : 8'h7F;
					4'd8: res = {1'b0, c.z};
					4'd9: res = {1'b0, c.w};
					default: res = SYX_END;
				endcase
			end
			default: res = 8'h00;
		endcase
		return res;
	endfunction

endpackage

FILE: design/midienc_front.sv
module midienc_front (
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [3:0]         func,
	input  logic signed [15:0] track_number,
	input  logic signed [15:0] arg_a,
	input  logic signed [15:0] arg_b,
	input  logic signed [15:0] arg_c,
	input  midienc_pkg::qstat_t q_stat,
	output logic               push,
	output midienc_pkg::cmd_t  cmd
);
	import midienc_pkg::*;

	logic signed [16:0] trk_m1;
	logic signed [16:0] a_ext;
	logic signed [16:0] a_m1;
	logic signed [16:0] a_p64;
	logic signed [16:0] b_ext;
	logic signed [16:0] c_ext;
	logic [6:0]         ch7;
	logic [3:0]         ch;
	logic [6:0]         sa;
	logic [6:0]         sa_m1;
	logic [6:0]         sa_p64;
	logic [6:0]         sa_12;
	logic [6:0]         sb;
	logic [6:0]         mode;
	logic [6:0]         dev;
	logic [13:0]        bend;
	logic [6:0]         part;
	logic [6:0]         sum;
	logic [6:0]         csum;

	// Sign-extend the arguments so that offsets cannot wrap.
	assign trk_m1 = $signed({track_number[15], track_number}) - 17'sd1;
	assign a_ext  = $signed({arg_a[15], arg_a});
	assign a_m1   = a_ext - 17'sd1;
	assign a_p64  = a_ext + 17'sd64;
	assign b_ext  = $signed({arg_b[15], arg_b});
	assign c_ext  = $signed({arg_c[15], arg_c});

	// Saturate every argument to the range its message allows.
	assign ch7    = sat_hi(trk_m1, 7'd15);
	assign ch     = ch7[3:0];
	assign sa     = sat_hi(a_ext, 7'd127);
	assign sa_m1  = sat_hi(a_m1, 7'd127);
	assign sa_p64 = sat_hi(a_p64, 7'd127);
	assign sa_12  = sat_hi(a_ext, 7'd12);
	assign sb     = sat_hi(b_ext, 7'd127);
	assign mode   = sat_hi(b_ext, 7'd2);
	assign dev    = sat_hi(c_ext, 7'd31);

	// Pitch bend is clamped to 14 bits and offset to the center, which flips the top bit.
	always_comb begin
		if (arg_a < -16'sd8192) begin
			bend = 14'h0000;
		end else if (arg_a > 16'sd8191) begin
			bend = 14'h3FFF;
		end else begin
			bend = arg_a[13:0] ^ 14'h2000;
		end
	end

	// Drum part address: channel 10 is part 0x10, the rest follow in order from 0x11.
	always_comb begin
		if (ch == 4'd9) begin
			part = 7'h10;
		end else if (ch < 4'd9) begin
			part = 7'h11 + {3'd0, ch};
		end else begin
			part = 7'h10 + {3'd0, ch};
		end
	end

	// Checksum makes address plus data sum to zero modulo 128.
	assign sum  = GS_ADDR_HI + part + DRUM_ADDR + mode;
	assign csum = 7'd0 - sum;

	// Pack the request into the queue entry.
	always_comb begin
		cmd       = '0;
		cmd.func  = func;
		cmd.ch    = ch;
		case (func)
			FN_NOTE_ON: begin
				cmd.count = 4'd3;
				cmd.x     = sa;
				cmd.y     = sb;
			end
			FN_NOTE_OFF: begin
				cmd.count = 4'd3;
				cmd.x     = sa;
			end
			FN_PROGRAM: begin
				cmd.count = 4'd2;
				cmd.x     = sa_m1;
			end
			FN_BANK_PRG: begin
				cmd.count = 4'd5;
				cmd.x     = sa_m1;
				cmd.y     = sb;
			end
			FN_PAN: begin
				cmd.count = 4'd3;
				cmd.x     = sa_p64;
			end
			FN_VOLUME: begin
				cmd.count = 4'd3;
				cmd.x     = sa;
			end
			FN_BEND_SENS: begin
				cmd.count = 4'd15;
				cmd.x     = sa_12;
			end
			FN_BEND: begin
				cmd.count = 4'd3;
				cmd.x     = bend[6:0];
				cmd.y     = bend[13:7];
			end
			FN_GM_ON: begin
				cmd.count = 4'd6;
			end
			FN_GS_RESET: begin
				cmd.count = 4'd11;
				cmd.x     = dev;
				cmd.y     = 7'h00;
				cmd.z     = 7'h00;
				cmd.w     = ROLAND_ID[6:0];
			end
			FN_GS_DRUM: begin
				cmd.count = 4'd11;
				cmd.x     = dev;
				cmd.y     = part;
				cmd.z     = mode;
				cmd.w     = csum;
			end
			default: begin
				cmd.count = 4'd0;
			end
		endcase
	end

	// Unknown kinds are accepted and dropped; they produce no bytes.
	assign req_ready = !q_stat.full;
	assign push      = req_valid && req_ready && (cmd.count != 4'd0);

endmodule

FILE: design/midienc_queue.sv
module midienc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  midienc_pkg::cmd_t  wr_cmd,
	input  logic               pop,
	output midienc_pkg::cmd_t  rd_cmd,
	output midienc_pkg::qstat_t q_stat
);
	import midienc_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       do_push;
	logic       do_pop;

	assign q_stat.full  = (level_q == 2'd2);
	assign q_stat.empty = (level_q == 2'd0);
	assign q_stat.level = level_q;
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign rd_cmd       = entry_q[rd_ptr_q];

	// Two-entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: level_q <= level_q + 2'd1;
				2'b01: level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

FILE: design/midienc_back.sv
module midienc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  midienc_pkg::qstat_t q_stat,
	input  midienc_pkg::cmd_t   rd_cmd,
	output logic                pop,
	output logic                byte_valid,
	input  logic                byte_ready,
	output logic [7:0]          msg_byte,
	output logic                last_byte
);
	import midienc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EMIT = 2'b10
	} state_t;

	state_t     state_q;
	cmd_t       cur_q;
	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       can_load;
	logic       is_last;

	assign can_load   = !valid_q || byte_ready;
	assign is_last    = (idx_q == cur_q.count - 4'd1);
	assign pop        = (state_q == S_IDLE) && !q_stat.empty;
	assign byte_valid = valid_q;
	assign msg_byte   = byte_q;
	assign last_byte  = last_q;

	// Current request, taken from the queue when idle.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_cmd;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && can_load) begin
			byte_q <= byte_at(cur_q, idx_q);
			last_q <= is_last;
		end
	end

	// Sequencer: one byte per cycle into the output register while the receiver takes them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (byte_valid && byte_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						idx_q   <= 4'd0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_load) begin
						valid_q <= 1'b1;
						idx_q   <= idx_q + 4'd1;
						if (is_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/midi_message_encoder.sv
// MIDI message encoder. Each request word names a message kind, a 1-based channel
// and up to three signed arguments, all saturated to their legal ranges; the block
// returns the message bytes one word at a time, with last_byte set on the final byte
// of the request. Unknown kinds (11 to 15) are accepted and produce no bytes. The
// front end classifies a request in the cycle it is accepted and places it in a
// two-entry queue, so up to two requests can wait while bytes are still going out.
// The back end emits one byte per cycle into an output register while the receiver
// keeps taking them, and passes through an idle state to fetch each request from the
// queue between requests; a request carries n bytes (2 to 15).
module midi_message_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [3:0]         func,
	input  logic signed [15:0] track_number,
	input  logic signed [15:0] arg_a,
	input  logic signed [15:0] arg_b,
	input  logic signed [15:0] arg_c,
	output logic               byte_valid,
	input  logic               byte_ready,
	output logic [7:0]         msg_byte,
	output logic               last_byte
);
	import midienc_pkg::*;

	cmd_t   wr_cmd;
	cmd_t   rd_cmd;
	qstat_t q_stat;
	logic   push;
	logic   pop;

	midienc_front u_front (
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.track_number (track_number),
		.arg_a        (arg_a),
		.arg_b        (arg_b),
		.arg_c        (arg_c),
		.q_stat       (q_stat),
		.push         (push),
		.cmd          (wr_cmd)
	);

	midienc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.q_stat (q_stat)
	);

	midienc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.rd_cmd     (rd_cmd),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.msg_byte   (msg_byte),
		.last_byte  (last_byte)
	);

	// The bytes of one request follow each other without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && !last_byte |=> byte_valid)
		else $error("gap inside a request's byte stream");

	// The queue never holds more than its two entries.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level != 2'd3)
		else $error("queue level out of range");

	// An unknown kind never adds a queue entry.
	a_drop_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (func > FN_GS_DRUM) |=> q_stat.level <= $past(q_stat.level))
		else $error("unknown request entered the queue");

endmodule
